@@ design/bdqd_pkg.sv @@
// ----------------------------------------------------------------------------
// bdqd_pkg
// Shared request codes, port field widths and controller/datapath structs
// for the bounded deque with delete.
// ----------------------------------------------------------------------------
package bdqd_pkg;

    localparam int REQ_W      = 3;
    localparam int VAL_W      = 32;
    localparam int CNT_OUT_W  = 5;
    localparam int MAX_DATA_W = 64;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 72;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REVERSE    = 3'd5;

    typedef struct packed {
        logic load_req;
        logic exec;
        logic scan_init;
        logic scan_next;
        logic shift_init;
        logic shift_rd;
        logic shift_wr;
        logic shift_end;
        logic rd_ends;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_delete;
        logic count_zero;
        logic match;
        logic scan_last;
        logic shift_last;
        logic out_busy;
    } ctrl_sts_t;

endpackage

@@ design/bdqd_ram.sv @@
// ----------------------------------------------------------------------------
// bdqd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bdqd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/bdqd_ctrl.sv @@
// ----------------------------------------------------------------------------
// bdqd_ctrl
// Request sequencer: accepts a word, runs update, search and shift steps,
// reads both ends and hands the result to the output register.
// ----------------------------------------------------------------------------
module bdqd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output bdqd_pkg::ctrl_cmd_t   cmd,
    input  bdqd_pkg::ctrl_sts_t   sts
);
    import bdqd_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_EXEC     = 3'd1;
    localparam logic [2:0] ST_SCAN_RD  = 3'd2;
    localparam logic [2:0] ST_SCAN_CMP = 3'd3;
    localparam logic [2:0] ST_SH_RD    = 3'd4;
    localparam logic [2:0] ST_SH_WR    = 3'd5;
    localparam logic [2:0] ST_RD_ENDS  = 3'd6;
    localparam logic [2:0] ST_LOAD     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.is_delete) begin
                    cmd.scan_init = 1'b1;
                    state_next    = sts.count_zero ? ST_RD_ENDS : ST_SCAN_RD;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = ST_RD_ENDS;
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (sts.match) begin
                    cmd.shift_init = 1'b1;
                    state_next     = ST_SH_RD;
                end else if (sts.scan_last) begin
                    state_next = ST_RD_ENDS;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_SH_RD: begin
                if (sts.shift_last) begin
                    cmd.shift_end = 1'b1;
                    state_next    = ST_RD_ENDS;
                end else begin
                    cmd.shift_rd = 1'b1;
                    state_next   = ST_SH_WR;
                end
            end
            ST_SH_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = ST_SH_RD;
            end
            ST_RD_ENDS: begin
                cmd.rd_ends = 1'b1;
                state_next  = ST_LOAD;
            end
            ST_LOAD: begin
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    cmd.rd_ends = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted word did not start execution");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !sts.out_busy)
        else $error("result loaded over a waiting word");

    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_req, cmd.exec, cmd.shift_rd, cmd.shift_wr,
                  cmd.rd_ends, cmd.load_out}))
        else $error("overlapping datapath steps");

endmodule

@@ design/bdqd_datapath.sv @@
// ----------------------------------------------------------------------------
// bdqd_datapath
// Circular store with head index, count and direction flag, search and
// shift addressing, end readout and the result output register.
// ----------------------------------------------------------------------------
module bdqd_datapath #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bdqd_pkg::ctrl_cmd_t               cmd,
    output bdqd_pkg::ctrl_sts_t               sts,
    input  logic [bdqd_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [bdqd_pkg::M_TDATA_W-1:0]    m_tdata
);
    import bdqd_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [REQ_W-1:0]     req_reg;
    logic [DATA_W-1:0]    val_reg;
    logic [IDX_W-1:0]     head_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 rev_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic                 acc_reg;
    logic                 found_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic                 full;
    logic                 empty;
    logic [CNT_W-1:0]     count_m1;
    logic [CNT_W-1:0]     scan_off;
    logic [CNT_W-1:0]     front_off;
    logic [CNT_W-1:0]     back_off;
    logic [IDX_W-1:0]     head_dec;
    logic                 push_start;
    logic                 pop_start;

    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [DATA_W-1:0]    wdata;
    logic [IDX_W-1:0]     raddr_a;
    logic [IDX_W-1:0]     raddr_b;
    logic [DATA_W-1:0]    rdata_a;
    logic [DATA_W-1:0]    rdata_b;

    logic [MAX_DATA_W-1:0]      front_wide;
    logic [MAX_DATA_W-1:0]      back_wide;
    logic [CNT_W+CNT_OUT_W-1:0] count_wide;

    assign full       = (count_reg == DEPTH_C);
    assign empty      = (count_reg == '0);
    assign count_m1   = count_reg - 1'b1;
    assign scan_off   = rev_reg ? (count_m1 - idx_reg) : idx_reg;
    assign front_off  = rev_reg ? count_m1 : '0;
    assign back_off   = rev_reg ? '0 : count_m1;
    assign head_dec   = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign push_start = (req_reg == REQ_PUSH_FRONT) != rev_reg;
    assign pop_start  = (req_reg == REQ_POP_FRONT) != rev_reg;

    always_comb begin
        we    = 1'b0;
        waddr = phys(head_reg, idx_reg);
        wdata = val_reg;
        if (cmd.exec && !full
            && (req_reg == REQ_PUSH_FRONT || req_reg == REQ_PUSH_BACK)) begin
            we    = 1'b1;
            waddr = push_start ? head_dec : phys(head_reg, count_reg);
        end else if (cmd.shift_wr) begin
            we    = 1'b1;
            wdata = rdata_a;
        end
    end

    always_comb begin
        priority if (cmd.shift_rd) begin
            raddr_a = phys(head_reg, idx_reg + 1'b1);
        end else if (cmd.rd_ends) begin
            raddr_a = phys(head_reg, front_off);
        end else begin
            raddr_a = phys(head_reg, scan_off);
        end
    end

    assign raddr_b = phys(head_reg, back_off);

    bdqd_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_front (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    bdqd_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_back (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    assign sts.is_delete  = (req_reg == REQ_DELETE);
    assign sts.count_zero = empty;
    assign sts.match      = (rdata_a == val_reg);
    assign sts.scan_last  = (idx_reg == count_m1);
    assign sts.shift_last = ((CNT_W+1)'(idx_reg) + 1'b1) >= (CNT_W+1)'(count_reg);
    assign sts.out_busy   = out_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                unique case (req_reg)
                    REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                        if (!full) begin
                            if (push_start) begin
                                head_reg <= head_dec;
                            end
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    REQ_POP_FRONT, REQ_POP_BACK: begin
                        if (!empty) begin
                            if (pop_start) begin
                                head_reg <= phys(head_reg, CNT_W'(1));
                            end
                            count_reg <= count_m1;
                        end
                    end
                    REQ_REVERSE: begin
                        rev_reg <= ~rev_reg;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.shift_end) begin
                count_reg <= count_m1;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign front_wide = empty ? '0 : MAX_DATA_W'(rdata_a);
    assign back_wide  = empty ? '0 : MAX_DATA_W'(rdata_b);
    assign count_wide = (CNT_W+CNT_OUT_W)'(count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg   <= s_tdata[REQ_W-1:0];
            val_reg   <= DATA_W'(s_tdata[REQ_W +: VAL_W]);
            acc_reg   <= 1'b1;
            found_reg <= 1'b0;
        end
        if (cmd.exec && full
            && (req_reg == REQ_PUSH_FRONT || req_reg == REQ_PUSH_BACK)) begin
            acc_reg <= 1'b0;
        end
        if (cmd.shift_end) begin
            found_reg <= 1'b1;
        end
        if (cmd.scan_init) begin
            idx_reg <= '0;
        end else if (cmd.scan_next || cmd.shift_wr) begin
            idx_reg <= idx_reg + 1'b1;
        end else if (cmd.shift_init) begin
            idx_reg <= scan_off;
        end
        if (cmd.load_out) begin
            out_data_reg <= {back_wide[VAL_W-1:0], front_wide[VAL_W-1:0], empty,
                             count_wide[CNT_OUT_W-1:0], found_reg, acc_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_delete_drops_one: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_end |=> count_reg == CNT_W'($past(count_reg) - 1'b1))
        else $error("delete did not remove exactly one entry");

    a_refuse_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && !acc_reg) |-> full)
        else $error("push refused while space remained");

endmodule

@@ design/bounded_deque_with_delete_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_with_delete_unit
// Bounded double-ended queue with push/pop at both ends, delete of the
// first matching value and order reversal.
//
// Input word (s_*): one request, req_type and value. Output word (m_*): one
// result per request with accepted, found, count, empty and both end values.
// A request is taken only when the unit is idle; the result waits in an
// output register, so a new request is taken while the previous result is
// still stalled on m_tready. Processing stalls only when a second result is
// ready before the first has been taken.
// Push, pop, reverse and unused codes: the input word is executed, both ends
// are read and the result is loaded. Delete: each slot examined is read and
// then compared; on a match each entry behind it is read and written one slot
// down, then the count drops by one. No new request is taken until the result
// of the previous one has been loaded. Search and shift use one read port of
// the store; its second copy's read port only reads the back end.
// Reset empties the queue (head, count and direction cleared) and drops any
// waiting result; the store itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module bounded_deque_with_delete_unit #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // req_type[2:0], value[34:3], zero[39:35]
    input  logic [bdqd_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // accepted[0], found[1], entry_count[6:2], is_empty[7],
    // front_value[39:8], back_value[71:40]
    output logic [bdqd_pkg::M_TDATA_W-1:0]    m_tdata
);
    import bdqd_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    bdqd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    bdqd_datapath #(.DEPTH(DEPTH), .DATA_W(DATA_W)) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
